// ===== rtl/swfd_pkg.sv =====
// Shared types and constants for the signed word ALU with floored division.
// Used by every module under rtl/; depends on nothing.
package swfd_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned CmdW  = 2;
  // One quotient bit per divide stage.
  localparam int unsigned DivStages = WordW;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Payload that travels down the pipeline with each item.
  typedef struct packed {
    cmd_t  cmd;
    word_t alu_res;   // add/sub/mul result, settled in the first stage
    word_t a_raw;     // dividend as given, returned as remainder on zero divisor
    logic  sign_a;
    logic  sign_b;
    logic  dz;
    word_t dvs_mag;   // |b|
    word_t part_rem;  // partial remainder magnitude
    word_t quo;       // dividend bits shifting out, quotient bits shifting in
  } stage_t;

endpackage

// ===== rtl/swfd_prep.sv =====
// Entry stage: add, subtract and multiply results, operand magnitudes and signs.
// Depends on swfd_pkg.
module swfd_prep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  swfd_pkg::cmd_t        cmd,
  input  swfd_pkg::word_t       op_a,
  input  swfd_pkg::word_t       op_b,
  output logic                  valid_o,
  output swfd_pkg::stage_t      stage_o
);

  logic             valid_r;
  swfd_pkg::stage_t stage_r;
  swfd_pkg::stage_t stage_nxt;

  always_comb begin
    stage_nxt          = '0;
    stage_nxt.cmd      = cmd;
    stage_nxt.a_raw    = op_a;
    stage_nxt.sign_a   = op_a[swfd_pkg::WordW-1];
    stage_nxt.sign_b   = op_b[swfd_pkg::WordW-1];
    stage_nxt.dz       = (cmd == swfd_pkg::CMD_DIV) && (op_b == '0);
    // |most negative| still fits as an unsigned word
    stage_nxt.dvs_mag  = op_b[swfd_pkg::WordW-1] ? (~op_b + 1'b1) : op_b;
    stage_nxt.quo      = op_a[swfd_pkg::WordW-1] ? (~op_a + 1'b1) : op_a;
    stage_nxt.part_rem = '0;
    case (cmd)
      swfd_pkg::CMD_ADD: stage_nxt.alu_res = op_a + op_b;
      swfd_pkg::CMD_SUB: stage_nxt.alu_res = op_a - op_b;
      swfd_pkg::CMD_MUL: stage_nxt.alu_res = op_a * op_b;
      default:           stage_nxt.alu_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

// ===== rtl/swfd_div_stage.sv =====
// One restoring-division step: produces one quotient bit per stage.
// Depends on swfd_pkg.
module swfd_div_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             valid_i,
  input  swfd_pkg::stage_t stage_i,
  output logic             valid_o,
  output swfd_pkg::stage_t stage_o
);

  logic                      valid_r;
  swfd_pkg::stage_t          stage_r;
  swfd_pkg::stage_t          stage_nxt;
  logic [swfd_pkg::WordW:0]  rem_sh;
  logic [swfd_pkg::WordW:0]  diff;

  always_comb begin
    rem_sh    = {stage_i.part_rem, stage_i.quo[swfd_pkg::WordW-1]};
    diff      = rem_sh - {1'b0, stage_i.dvs_mag};
    stage_nxt = stage_i;
    if (!diff[swfd_pkg::WordW]) begin
      stage_nxt.part_rem = diff[swfd_pkg::WordW-1:0];
      stage_nxt.quo      = {stage_i.quo[swfd_pkg::WordW-2:0], 1'b1};
    end else begin
      stage_nxt.part_rem = rem_sh[swfd_pkg::WordW-1:0];
      stage_nxt.quo      = {stage_i.quo[swfd_pkg::WordW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

// ===== rtl/swfd_post.sv =====
// Exit stage: sign and floor fix of quotient and remainder, output select.
// Depends on swfd_pkg.
module swfd_post (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             valid_i,
  input  swfd_pkg::stage_t stage_i,
  output logic             out_valid,
  output swfd_pkg::word_t  out_result,
  output swfd_pkg::word_t  out_remainder,
  output logic             out_div_by_zero
);

  logic            valid_r;
  swfd_pkg::word_t result_r;
  swfd_pkg::word_t remainder_r;
  logic            dz_r;
  swfd_pkg::word_t result_nxt;
  swfd_pkg::word_t remainder_nxt;
  logic            dz_nxt;
  logic            differ;
  logic            floor_fix;
  logic            rem_neg;
  swfd_pkg::word_t rem_mag;
  swfd_pkg::word_t qm;

  always_comb begin
    qm        = stage_i.quo;
    differ    = stage_i.sign_a ^ stage_i.sign_b;
    floor_fix = differ && (stage_i.part_rem != '0);
    // floored remainder takes the divisor's sign: |r| = |b| - |r_trunc|
    rem_mag   = floor_fix ? (stage_i.dvs_mag - stage_i.part_rem) : stage_i.part_rem;
    rem_neg   = floor_fix ? stage_i.sign_b : stage_i.sign_a;
    result_nxt    = stage_i.alu_res;
    remainder_nxt = '0;
    dz_nxt        = 1'b0;
    if (stage_i.cmd == swfd_pkg::CMD_DIV) begin
      if (stage_i.dz) begin
        result_nxt    = '0;
        remainder_nxt = stage_i.a_raw;
        dz_nxt        = 1'b1;
      end else begin
        if (floor_fix) begin
          result_nxt = ~qm;             // -q - 1
        end else if (differ) begin
          result_nxt = ~qm + 1'b1;
        end else begin
          result_nxt = qm;
        end
        remainder_nxt = rem_neg ? (~rem_mag + 1'b1) : rem_mag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_r    <= result_nxt;
      remainder_r <= remainder_nxt;
      dz_r        <= dz_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_result      = result_r;
  assign out_remainder   = remainder_r;
  assign out_div_by_zero = dz_r;

endmodule

// ===== rtl/signed_word_alu_floor_div_core.sv =====
// Top level of the 16-bit signed ALU with floored division.
// Depends on swfd_pkg, swfd_prep, swfd_div_stage and swfd_post.
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid, in_stall, in_command, in_operand_a/b | into block
//   out     | out_valid, out_stall, out_result,          | out of block
//           | out_remainder, out_div_by_zero             |
//
// Every command passes through the same stages: one entry stage, 16 divide stages
// (one quotient bit each) and one exit stage. One transfer per cycle is taken unless in_stall is high.
// The whole pipeline moves together; it holds only while the output register
// is full and stalled, and in_stall is raised in exactly those cycles.
// Reset (synchronous, rst_n low) clears all stage valid bits.
module signed_word_alu_floor_div_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [swfd_pkg::CmdW-1:0]          in_command,
  input  logic [swfd_pkg::WordW-1:0]         in_operand_a,
  input  logic [swfd_pkg::WordW-1:0]         in_operand_b,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [swfd_pkg::WordW-1:0]         out_result,
  output logic [swfd_pkg::WordW-1:0]         out_remainder,
  output logic                               out_div_by_zero
);

  logic             adv;
  logic             valid_s [swfd_pkg::DivStages+1];
  swfd_pkg::stage_t stage_s [swfd_pkg::DivStages+1];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  swfd_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_valid(in_valid),
    .cmd     (swfd_pkg::cmd_t'(in_command)),
    .op_a    (in_operand_a),
    .op_b    (in_operand_b),
    .valid_o (valid_s[0]),
    .stage_o (stage_s[0])
  );

  for (genvar i = 0; i < swfd_pkg::DivStages; i++) begin : g_div
    swfd_div_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .valid_i(valid_s[i]),
      .stage_i(stage_s[i]),
      .valid_o(valid_s[i+1]),
      .stage_o(stage_s[i+1])
    );
  end

  swfd_post u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .valid_i        (valid_s[swfd_pkg::DivStages]),
    .stage_i        (stage_s[swfd_pkg::DivStages]),
    .out_valid      (out_valid),
    .out_result     (out_result),
    .out_remainder  (out_remainder),
    .out_div_by_zero(out_div_by_zero)
  );

endmodule

// ===== tb/swfd_result_checker.sv =====
// Result checker for signed_word_alu_floor_div_core: watches both channels,
// predicts each result from the accepted operands and compares in order.
// Depends on swfd_pkg.
module swfd_result_checker
  import swfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [CmdW-1:0]  in_command,
  input  logic [WordW-1:0] in_operand_a,
  input  logic [WordW-1:0] in_operand_b,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [WordW-1:0] out_result,
  input  logic [WordW-1:0] out_remainder,
  input  logic             out_div_by_zero,
  output int               mismatches,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t result;
    word_t remainder;
    logic  div_by_zero;
  } alu_out_t;

  alu_out_t due_results[$];

  function automatic alu_out_t compute_alu_result(cmd_t cmd, word_t a, word_t b);
    alu_out_t o;
    int sa;
    int sb;
    int q;
    int r;
    o  = '0;
    sa = $signed(a);
    sb = $signed(b);
    case (cmd)
      CMD_ADD: o.result = a + b;
      CMD_SUB: o.result = a - b;
      CMD_MUL: o.result = a * b;
      default: begin
        if (b == '0) begin
          o.remainder   = a;
          o.div_by_zero = 1'b1;
        end else begin
          // truncate, then floor: step down whenever the signs differ and
          // something is left over, even if the truncated quotient is zero
          q = sa / sb;
          r = sa % sb;
          if (r != 0 && ((sa < 0) != (sb < 0))) q = q - 1;
          r = sa - sb * q;
          o.result    = q[WordW-1:0];
          o.remainder = r[WordW-1:0];
        end
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : watch
    alu_out_t want;
    alu_out_t got;
    if (!rst_n) begin
      due_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(compute_alu_result(cmd_t'(in_command),
                                                 in_operand_a, in_operand_b));
      end
      if (out_valid && !out_stall) begin
        got = '{out_result, out_remainder, out_div_by_zero};
        if (due_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transfer with nothing outstanding: res=%h rem=%h dz=%b",
                     $realtime, got.result, got.remainder, got.div_by_zero);
          mismatches <= mismatches + 1;
        end else begin
          want = due_results.pop_front();
          if (got.result !== want.result || got.remainder !== want.remainder ||
              got.div_by_zero !== want.div_by_zero) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected res=%h rem=%h dz=%b, got res=%h rem=%h dz=%b",
                       $realtime, want.result, want.remainder, want.div_by_zero,
                       got.result, got.remainder, got.div_by_zero);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

// ===== tb/signed_word_alu_floor_div_core_test.sv =====
// Top of the testbench for signed_word_alu_floor_div_core: clock, reset,
// operand stimulus with random idling, and the verdict.
// Depends on swfd_pkg, the core and swfd_result_checker.
module signed_word_alu_floor_div_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import swfd_pkg::*;

  localparam int ItemsPerPhase = 340;
  localparam int HoldCycles    = 300;

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [CmdW-1:0]  in_command   = '0;
  logic [WordW-1:0] in_operand_a = '0;
  logic [WordW-1:0] in_operand_b = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [WordW-1:0] out_result;
  logic [WordW-1:0] out_remainder;
  logic             out_div_by_zero;

  int send_idle_pct = 25;
  int recv_idle_pct = 64;
  bit hold_req      = 1'b0;
  int mismatches;
  int pending;

  signed_word_alu_floor_div_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall), .out_result(out_result),
    .out_remainder(out_remainder), .out_div_by_zero(out_div_by_zero)
  );

  swfd_result_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_stall(out_stall), .out_result(out_result),
    .out_remainder(out_remainder), .out_div_by_zero(out_div_by_zero),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stalls, or one long hold-off on request.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Returns once the transfer has happened.
  task automatic send_op(input cmd_t cmd, input word_t a, input word_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Biased toward the corners: zero, -1, most negative/positive, small values.
  function automatic word_t pick_operand();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4:       return word_t'($urandom_range(1, 9));
      5:       return -word_t'($urandom_range(1, 9));
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send_random_ops(input int count);
    for (int i = 0; i < count; i++)
      send_op(cmd_t'($urandom_range(3)), pick_operand(), pick_operand());
  endtask

  initial begin : stimulus
    int waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_op(CMD_ADD, 16'h7FFF, 16'h0001);
    send_op(CMD_ADD, 16'hFFFF, 16'hFFFF);
    send_op(CMD_SUB, 16'h0000, 16'h0001);
    send_op(CMD_SUB, 16'h8000, 16'h0001);
    send_op(CMD_MUL, 16'h8000, 16'hFFFF);
    send_op(CMD_MUL, 16'hFFFF, 16'hFFFF);
    send_op(CMD_MUL, 16'h7FFF, 16'h7FFF);
    send_op(CMD_DIV, 16'h0007, 16'h0002);
    send_op(CMD_DIV, 16'hFFF9, 16'h0002);
    send_op(CMD_DIV, 16'h0007, 16'hFFFE);
    send_op(CMD_DIV, 16'hFFF9, 16'hFFFE);
    // truncated quotient zero, signs differ: still floors to -1
    send_op(CMD_DIV, 16'h0001, 16'hFFFE);
    send_op(CMD_DIV, 16'hFFFF, 16'h0002);
    send_op(CMD_DIV, 16'h7FFF, 16'h8000);
    send_op(CMD_DIV, 16'h0005, 16'h0000);
    send_op(CMD_DIV, 16'h8000, 16'h0000);
    send_op(CMD_DIV, 16'hFFFF, 16'h0000);
    send_op(CMD_DIV, 16'h8000, 16'hFFFF);
    send_op(CMD_DIV, 16'h8000, 16'h0001);
    send_op(CMD_DIV, 16'h8000, 16'h8000);
    send_op(CMD_DIV, 16'h0000, 16'hFFFD);
    send_op(CMD_DIV, 16'h0006, 16'hFFFD);

    send_random_ops(ItemsPerPhase);
    send_idle_pct = 64;
    recv_idle_pct = 25;
    send_random_ops(ItemsPerPhase);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    send_random_ops(ItemsPerPhase);
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
